@@ hdl/sync_header_frame_parser_with_crc_core_assert.svh @@
`ifndef SYNC_HEADER_FRAME_PARSER_WITH_CRC_CORE_ASSERT_SVH
`define SYNC_HEADER_FRAME_PARSER_WITH_CRC_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SHFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shfp assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SHFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shfp assertion failed");

`endif

@@ hdl/shfp_pkg.sv @@
package shfp_pkg;

    localparam int unsigned SYNC_LEN    = 6;
    localparam int unsigned CRC_INIT_HI = 6;
    localparam int unsigned CRC_INIT_LO = 7;
    localparam int unsigned LEN_INDEX   = 8;
    localparam int unsigned DATA_INDEX  = 9;
    localparam int unsigned DATA_END    = 8;
    localparam int unsigned FRAME_EXTRA = 11;
    localparam int unsigned CMP_W       = 9;

    localparam logic [15:0] CRC_POLY = 16'h1041;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic  init;
        logic  start;
        byte_t init_hi;
        byte_t data;
    } crc_ctrl_t;

    typedef struct packed {
        logic busy;
        logic zero;
    } crc_stat_t;

    function automatic byte_t sync_byte(input logic [2:0] idx);
        byte_t b;
        case (idx)
            3'd0:    b = 8'hEB;
            3'd1:    b = 8'h90;
            3'd2:    b = 8'hEB;
            3'd3:    b = 8'h90;
            3'd4:    b = 8'hEB;
            3'd5:    b = 8'h90;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ hdl/shfp_rx_if.sv @@
interface shfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hdl/shfp_res_if.sv @@
interface shfp_res_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       last;

    modport source (output valid, output status, output payload_byte,
                    output payload_valid, output last, input ready);
    modport sink (input valid, input status, input payload_byte,
                  input payload_valid, input last, output ready);
endinterface

@@ hdl/sync_header_frame_parser_with_crc_core.sv @@
// Frame parser for a byte stream carrying frames of the form: sync header
// EB 90 EB 90 EB 90, two bytes that seed the CRC, a length byte L, L data bytes,
// two CRC bytes and a closing byte. Bytes are stored in a BUFFER_BYTES deep
// frame memory. The 16-bit CRC (poly 0x1041) is folded in as bytes arrive, one
// bit per cycle, so every byte from index 8 up to the one before the closing
// byte occupies the block (accept, shifting, return to idle); other bytes
// skip the shift state. After the closing byte the block emits either the
// L data bytes (one memory read per result, one result per cycle when the sink
// is ready) or one status result: status 1 on a CRC mismatch, status 0 with no
// data for an empty frame. A bad header byte or a frame that reaches
// BUFFER_BYTES-1 bytes drops the frame silently.
module sync_header_frame_parser_with_crc_core
    import shfp_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    shfp_rx_if.sink   rx,
    shfp_res_if.source res
);

    localparam int PW = $clog2(BUFFER_BYTES);
    localparam logic [PW-1:0] POS_MAX = PW'(BUFFER_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] rd_idx_reg;
    byte_t       prev_reg;
    byte_t       len_reg;
    logic        fail_reg;
    logic        res_valid_reg;
    logic        res_status_reg;
    logic        res_pv_reg;
    logic        res_last_reg;
    byte_t       res_byte_reg;

    byte_t       mem [BUFFER_BYTES];

    crc_ctrl_t   crc_ctrl;
    crc_stat_t   crc_stat;

    logic          accept;
    logic [PW-1:0] pos;
    logic [PW-1:0] pos_m1;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] rd_w;
    logic [CMP_W-1:0] len_w;
    logic          hdr_bad;
    logic          complete;
    logic          out_free;
    logic          emit_status;
    logic          load_byte;
    logic          load_status;
    logic          byte_last;

    assign accept   = (state_reg == ST_IDLE) && rx.valid;
    assign pos      = (pos_reg >= POS_MAX) ? '0 : pos_reg;
    assign pos_m1   = pos - PW'(1);
    assign pos_w    = CMP_W'(pos);
    assign rd_w     = CMP_W'(rd_idx_reg);
    assign len_w    = CMP_W'(len_reg);

    assign hdr_bad  = (pos >= PW'(1)) && (pos <= PW'(SYNC_LEN))
                      && (prev_reg != sync_byte(pos_m1[2:0]));
    assign complete = (pos > PW'(LEN_INDEX)) && (pos_w == len_w + CMP_W'(FRAME_EXTRA));

    assign out_free    = !res_valid_reg || res.ready;
    assign emit_status = fail_reg || (len_reg == 8'h00);
    assign load_status = (state_reg == ST_EMIT) && out_free && emit_status;
    assign load_byte   = (state_reg == ST_EMIT) && out_free && !emit_status;
    assign byte_last   = (rd_w == len_w + CMP_W'(DATA_END));

    assign crc_ctrl.init    = accept && !hdr_bad && (pos == PW'(CRC_INIT_LO));
    assign crc_ctrl.start   = accept && !hdr_bad && !complete && (pos >= PW'(LEN_INDEX));
    assign crc_ctrl.init_hi = prev_reg;
    assign crc_ctrl.data    = rx.rx_byte;

    shfp_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .stat  (crc_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            rd_idx_reg     <= '0;
            prev_reg       <= '0;
            len_reg        <= '0;
            fail_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= 1'b0;
            res_pv_reg     <= 1'b0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            if (load_status || load_byte)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        prev_reg <= rx.rx_byte;
                        if (hdr_bad)
                        begin
                            pos_reg <= '0;
                        end
                        else if (complete)
                        begin
                            pos_reg    <= '0;
                            fail_reg   <= !crc_stat.zero;
                            rd_idx_reg <= PW'(DATA_INDEX);
                            state_reg  <= ST_EMIT;
                        end
                        else
                        begin
                            pos_reg <= pos + PW'(1);
                            if (pos == PW'(LEN_INDEX))
                            begin
                                len_reg <= rx.rx_byte;
                            end
                            if (pos >= PW'(LEN_INDEX))
                            begin
                                state_reg <= ST_SHIFT;
                            end
                        end
                    end
                end
                ST_SHIFT:
                begin
                    if (!crc_stat.busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT:
                begin
                    if (load_status)
                    begin
                        res_status_reg <= fail_reg;
                        res_pv_reg     <= 1'b0;
                        res_last_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                    else if (load_byte)
                    begin
                        res_status_reg <= 1'b0;
                        res_pv_reg     <= 1'b1;
                        res_last_reg   <= byte_last;
                        rd_idx_reg     <= rd_idx_reg + PW'(1);
                        if (byte_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[pos] <= rx.rx_byte;
        end
        if (load_byte)
        begin
            res_byte_reg <= mem[rd_idx_reg];
        end
        else if (load_status)
        begin
            res_byte_reg <= 8'h00;
        end
    end

    assign rx.ready          = (state_reg == ST_IDLE);
    assign res.valid         = res_valid_reg;
    assign res.status        = res_status_reg;
    assign res.payload_byte  = res_byte_reg;
    assign res.payload_valid = res_pv_reg;
    assign res.last          = res_last_reg;

endmodule

@@ hdl/shfp_crc.sv @@
module shfp_crc
    import shfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  crc_ctrl_t ctrl,
    output crc_stat_t stat
);

    logic [15:0] crc_reg, crc_next;
    byte_t       sh_reg, sh_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;

    always_comb
    begin
        crc_next  = crc_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctrl.init)
        begin
            crc_next = {ctrl.init_hi, ctrl.data};
        end
        else if (ctrl.start)
        begin
            sh_next   = ctrl.data;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one bit per cycle, msb first
            crc_next = {crc_reg[14:0], sh_reg[7]} ^ (crc_reg[15] ? CRC_POLY : 16'h0000);
            sh_next  = {sh_reg[6:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        sh_reg  <= sh_next;
    end

    assign stat.busy = busy_reg;
    assign stat.zero = (crc_reg == 16'h0000);

endmodule

@@ hdl/shfp_checker.sv @@
`include "sync_header_frame_parser_with_crc_core_assert.svh"

module shfp_checker
    import shfp_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  res_valid,
    input logic  res_ready,
    input logic  status,
    input byte_t payload_byte,
    input logic  payload_valid,
    input logic  last
);

    // a result not taken stays offered
    `SHFP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

    // a data byte never carries an error
    `SHFP_ASSERT_NOW(a_data_ok, res_valid && payload_valid, !status)

    // status items stand alone and close the frame
    `SHFP_ASSERT_NOW(a_status_last, res_valid && !payload_valid, last)

    // status items carry a zero byte
    `SHFP_ASSERT_NOW(a_status_zero, res_valid && !payload_valid, payload_byte == 8'h00)

endmodule

bind sync_header_frame_parser_with_crc_core shfp_checker u_shfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .status        (res.status),
    .payload_byte  (res.payload_byte),
    .payload_valid (res.payload_valid),
    .last          (res.last)
);
